@@ hw/rtl/okvt_pkg.sv @@
// ----------------------------------------------------------------------------
// okvt_pkg
// Types and fixed field widths shared by the ordered key/value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int FIELD_W     = 32;  // key, value, key_out, value_out
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int TUSER_W     = 3;   // op on input, status on output
    localparam int IN_TDATA_W  = 72;  // key, value, position, padded to bytes
    localparam int OUT_TDATA_W = 72;  // key_out, value_out, entry_count, padded

    typedef enum logic [TUSER_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_UPSERT  = 3'd2,
        OP_ERASE   = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_READ_AT = 3'd5
    } t_op;

    typedef enum logic [TUSER_W-1:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

endpackage

@@ hw/rtl/ordered_key_value_table.sv @@
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Bounded table of unique keys with values, kept in insertion order. One
// request per item; every request returns one result item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser=op, tdata=key,value,position
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tuser=status,
//                                                 tdata=key_out,value_out,entry_count
//
//  Flow, accept to result: a key search compares entries in order, one per
//  cycle, set by the single read port of the entry RAM, to the first match
//  or the table end; erase then closes up the later entries; read at position
//  reads one entry unless out of range; an unused op goes straight to the
//  result. The next item is taken in the cycle after the result is loaded.
//  Reset: synchronous; count cleared, RAM contents left as they are.
//  Stalls: a new item is taken while a result waits in the output register;
//  a finished request waits in its last step until that register frees.
// ----------------------------------------------------------------------------
module ordered_key_value_table #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] key, [63:32] value, [67:64] position, [71:68] zero
    input  logic [okvt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] op
    input  logic [okvt_pkg::TUSER_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] key_out, [63:32] value_out, [68:64] entry_count, [71:69] zero
    output logic [okvt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status
    output logic [okvt_pkg::TUSER_W-1:0]     o_m_axis_tuser
);

    localparam int KS = (KEY_BITS < okvt_pkg::FIELD_W) ? KEY_BITS : okvt_pkg::FIELD_W;
    localparam int VS = (VALUE_BITS < okvt_pkg::FIELD_W) ? VALUE_BITS : okvt_pkg::FIELD_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > okvt_pkg::POS_W) ? CW : okvt_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_READ,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state                    r_state,   n_state;
    okvt_pkg::t_op             r_op,      n_op;
    logic [KS-1:0]             r_key,     n_key;
    logic [VS-1:0]             r_val,     n_val;
    logic [okvt_pkg::POS_W-1:0] r_pos,    n_pos;
    logic [CW-1:0]             r_ptr,     n_ptr;
    logic                      r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]             r_cmp_idx, n_cmp_idx;
    logic                      r_hit,     n_hit;
    logic [AW-1:0]             r_at,      n_at;
    logic [VS-1:0]             r_hit_val, n_hit_val;
    logic [CW-1:0]             r_count,   n_count;
    okvt_pkg::t_status         r_status,  n_status;
    logic [KS-1:0]             r_kout,    n_kout;
    logic [VS-1:0]             r_vout,    n_vout;

    logic                          r_out_vld,    n_out_vld;
    okvt_pkg::t_status             r_out_status, n_out_status;
    logic [okvt_pkg::FIELD_W-1:0]  r_out_key,    n_out_key;
    logic [okvt_pkg::FIELD_W-1:0]  r_out_val,    n_out_val;
    logic [okvt_pkg::CNT_W-1:0]    r_out_cnt,    n_out_cnt;

    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [KS+VS-1:0] w_wdata;
    logic [KS+VS-1:0] w_rdata;
    logic [KS-1:0]   w_rd_key;
    logic [VS-1:0]   w_rd_val;
    logic            w_issue;
    logic            w_full;
    okvt_pkg::t_op   w_in_op;

    okvt_ram #(
        .WIDTH (KS + VS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key = w_rdata[VS +: KS];
    assign w_rd_val = w_rdata[0 +: VS];
    assign w_issue  = (r_ptr < r_count);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_in_op  = okvt_pkg::t_op'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_cnt, r_out_val, r_out_key};
    assign o_m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_pos        = r_pos;
        n_ptr        = r_ptr;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_hit        = r_hit;
        n_at         = r_at;
        n_hit_val    = r_hit_val;
        n_count      = r_count;
        n_status     = r_status;
        n_kout       = r_kout;
        n_vout       = r_vout;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_val    = r_out_val;
        n_out_cnt    = r_out_cnt;
        w_re         = 1'b0;
        w_raddr      = '0;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = {r_key, r_val};

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op      = w_in_op;
                    n_key     = i_s_axis_tdata[0 +: KS];
                    n_val     = i_s_axis_tdata[okvt_pkg::FIELD_W +: VS];
                    n_pos     = i_s_axis_tdata[2*okvt_pkg::FIELD_W +: okvt_pkg::POS_W];
                    n_status  = okvt_pkg::ST_OK;
                    n_kout    = i_s_axis_tdata[0 +: KS];
                    n_vout    = '0;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    case (w_in_op)
                        okvt_pkg::OP_READ_AT: n_state = S_READ;
                        okvt_pkg::OP_INSERT,
                        okvt_pkg::OP_UPDATE,
                        okvt_pkg::OP_UPSERT,
                        okvt_pkg::OP_ERASE,
                        okvt_pkg::OP_LOOKUP:  n_state = S_SCAN;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                // read one entry per cycle, compare it the cycle after
                w_re      = w_issue;
                w_raddr   = r_ptr[AW-1:0];
                n_cmp_vld = w_issue;
                n_cmp_idx = r_ptr[AW-1:0];
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_cmp_vld && (w_rd_key == r_key)) begin
                    n_hit     = 1'b1;
                    n_at      = r_cmp_idx;
                    n_hit_val = w_rd_val;
                    n_cmp_vld = 1'b0;
                    n_state   = S_ACT;
                end else if (!w_issue && !r_cmp_vld) begin
                    n_hit   = 1'b0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                case (r_op)
                    okvt_pkg::OP_INSERT,
                    okvt_pkg::OP_UPSERT: begin
                        if (r_hit) begin
                            if (r_op == okvt_pkg::OP_INSERT) begin
                                n_status = okvt_pkg::ST_PRESENT;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_at;
                            end
                        end else if (w_full) begin
                            n_status = okvt_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end
                    okvt_pkg::OP_UPDATE: begin
                        if (r_hit) begin
                            w_we    = 1'b1;
                            w_waddr = r_at;
                        end else begin
                            n_status = okvt_pkg::ST_NOT_FOUND;
                        end
                    end
                    okvt_pkg::OP_ERASE: begin
                        if (r_hit) begin
                            n_ptr     = CW'(r_at) + CW'(1);
                            n_cmp_vld = 1'b0;
                            n_state   = S_SHIFT;
                        end else begin
                            n_status = okvt_pkg::ST_NOT_FOUND;
                        end
                    end
                    okvt_pkg::OP_LOOKUP: begin
                        if (r_hit) begin
                            n_vout = r_hit_val;
                        end else begin
                            n_status = okvt_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                // entry i+1 read, then written to i on the following cycle
                w_re      = w_issue;
                w_raddr   = r_ptr[AW-1:0];
                n_cmp_vld = w_issue;
                n_cmp_idx = r_ptr[AW-1:0];
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_cmp_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_cmp_idx - AW'(1);
                    w_wdata = w_rdata;
                end
                if (!w_issue && !r_cmp_vld) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (PW'(r_pos) < PW'(r_count)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_pos);
                    n_state = S_RDWAIT;
                end else begin
                    n_status = okvt_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_kout  = w_rd_key;
                n_vout  = w_rd_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_key    = okvt_pkg::FIELD_W'(r_kout);
                    n_out_val    = okvt_pkg::FIELD_W'(r_vout);
                    n_out_cnt    = okvt_pkg::CNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_ptr        <= n_ptr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit        <= n_hit;
        r_at         <= n_at;
        r_hit_val    <= n_hit_val;
        r_status     <= n_status;
        r_kout       <= n_kout;
        r_vout       <= n_vout;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_val    <= n_out_val;
        r_out_cnt    <= n_out_cnt;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("RAM write while idle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start a request");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ($past(r_state) == S_ACT || $past(r_state) == S_SHIFT))
        else $error("entry count changed outside insert or erase");
`endif

endmodule

@@ hw/rtl/okvt_ram.sv @@
// ----------------------------------------------------------------------------
// okvt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/ordered_key_value_table_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_key_value_table_tb
// Self-checking bench for the insertion-ordered key/value table. Requests go
// in on the slave stream and a scoreboard keeps a shadow copy of the table,
// predicting status, key, value and count for every request. Each result on
// the master stream is compared field by field, in order. A short directed
// pass covers empty, full, duplicate, absent, edge-position and reserved-op
// cases. Random traffic follows, alternating grow and shrink phases over a
// small key pool, with random stalls on both sides and one long output
// hold-off.
// ----------------------------------------------------------------------------
module ordered_key_value_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1150;
    localparam int KEY_POOL_N   = 20;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT     = 17;
    // op codes the block treats as no operation
    localparam logic [okvt_pkg::TUSER_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [okvt_pkg::TUSER_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct {
        okvt_pkg::t_status          status;
        logic [31:0]                key;
        logic [31:0]                value;
        logic [okvt_pkg::CNT_W-1:0] count;
    } t_response;

    class table_scoreboard;
        logic [31:0] keys [TABLE_DEPTH];
        logic [31:0] vals [TABLE_DEPTH];
        int          count;
        int          errors;
        t_response   expected_responses[$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Apply one accepted request to the shadow table, queue its result.
        function void note_request(logic [okvt_pkg::TUSER_W-1:0] op, logic [31:0] key,
                                   logic [31:0] value, logic [okvt_pkg::POS_W-1:0] pos);
            t_response r;
            int        at;
            r.status = okvt_pkg::ST_OK;
            r.key    = key;
            r.value  = '0;
            at       = -1;
            for (int i = 0; i < count; i++) begin
                if (at < 0 && keys[i] == key) at = i;
            end
            case (op)
                okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
                    if (at >= 0) begin
                        if (op == okvt_pkg::OP_INSERT) r.status = okvt_pkg::ST_PRESENT;
                        else vals[at] = value;
                    end else if (count >= TABLE_DEPTH) begin
                        r.status = okvt_pkg::ST_FULL;
                    end else begin
                        keys[count] = key;
                        vals[count] = value;
                        count++;
                    end
                end
                okvt_pkg::OP_UPDATE: begin
                    if (at >= 0) vals[at] = value;
                    else r.status = okvt_pkg::ST_NOT_FOUND;
                end
                okvt_pkg::OP_ERASE: begin
                    if (at >= 0) begin
                        // later entries close up, order kept
                        for (int i = at; i + 1 < count; i++) begin
                            keys[i] = keys[i + 1];
                            vals[i] = vals[i + 1];
                        end
                        count--;
                    end else begin
                        r.status = okvt_pkg::ST_NOT_FOUND;
                    end
                end
                okvt_pkg::OP_LOOKUP: begin
                    if (at >= 0) r.value = vals[at];
                    else r.status = okvt_pkg::ST_NOT_FOUND;
                end
                okvt_pkg::OP_READ_AT: begin
                    if (int'(pos) < count) begin
                        r.key   = keys[pos];
                        r.value = vals[pos];
                    end else begin
                        r.status = okvt_pkg::ST_RANGE;
                    end
                end
                default: ;
            endcase
            r.count = okvt_pkg::CNT_W'(count);
            expected_responses.push_back(r);
        endfunction

        function void check_response(logic [okvt_pkg::TUSER_W-1:0] status,
                                     logic [31:0] key_out, logic [31:0] value_out,
                                     logic [okvt_pkg::CNT_W-1:0] cnt);
            t_response e;
            if (expected_responses.size() == 0) begin
                $error("unexpected result item: status %0d key %h value %h count %0d",
                       status, key_out, value_out, cnt);
                errors++;
                return;
            end
            e = expected_responses.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (key_out !== e.key) begin
                $error("key_out: expected %h, got %h", e.key, key_out);
                errors++;
            end
            if (value_out !== e.value) begin
                $error("value_out: expected %h, got %h", e.value, value_out);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [okvt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [okvt_pkg::TUSER_W-1:0]     i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [okvt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [okvt_pkg::TUSER_W-1:0]     o_m_axis_tuser;

    table_scoreboard sb = new();
    bit              quiet = 1'b0;          // no idling on either side
    bit              hold_request = 1'b0;   // ask receiver for a long hold-off
    int              cycles = 0;
    logic [31:0]     key_pool [KEY_POOL_N];

    ordered_key_value_table #(
        .DEPTH      (TABLE_DEPTH),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check on handshake, then pick next tready.
    always @(posedge i_clk) begin
        int hold_left;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_response(o_m_axis_tuser, o_m_axis_tdata[31:0],
                              o_m_axis_tdata[63:32], o_m_axis_tdata[68:64]);
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("ordered_key_value_table: mismatch");
        $finish;
    end

    task automatic drive_request(logic [okvt_pkg::TUSER_W-1:0] op, logic [31:0] key,
                                 logic [31:0] value, logic [okvt_pkg::POS_W-1:0] pos);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0, pos, value, key};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, key, value, pos);
    endtask

    // Mostly keys that are in the table or in the pool, sometimes any key.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (sb.count > 0 && r < 45) return sb.keys[$urandom_range(sb.count - 1)];
        if (r < 90) return key_pool[$urandom_range(KEY_POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic logic [okvt_pkg::TUSER_W-1:0] pick_op(bit grow);
        int r;
        r = $urandom_range(99);
        if (grow) begin
            if (r < 30) return okvt_pkg::OP_INSERT;
            if (r < 50) return okvt_pkg::OP_UPSERT;
            if (r < 60) return okvt_pkg::OP_UPDATE;
            if (r < 68) return okvt_pkg::OP_ERASE;
            if (r < 82) return okvt_pkg::OP_LOOKUP;
            if (r < 96) return okvt_pkg::OP_READ_AT;
        end else begin
            if (r < 10) return okvt_pkg::OP_INSERT;
            if (r < 16) return okvt_pkg::OP_UPSERT;
            if (r < 26) return okvt_pkg::OP_UPDATE;
            if (r < 66) return okvt_pkg::OP_ERASE;
            if (r < 80) return okvt_pkg::OP_LOOKUP;
            if (r < 96) return okvt_pkg::OP_READ_AT;
        end
        return (r < 98) ? OP_RSVD_6 : OP_RSVD_7;
    endfunction

    initial begin : stimulus
        logic [31:0]                k;
        logic [okvt_pkg::POS_W-1:0] p;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table
        drive_request(okvt_pkg::OP_READ_AT, 32'h1234_5678, 32'h0, 4'd0);
        drive_request(okvt_pkg::OP_ERASE, 32'h0000_0005, 32'h0, 4'd0);
        // fill to full, key and value extremes included
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            k = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : (32'h100 + i);
            drive_request(okvt_pkg::OP_INSERT, k, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 4'(i));
        end
        drive_request(okvt_pkg::OP_INSERT, 32'hDEAD_0001, 32'h1, 4'd0);   // full
        drive_request(okvt_pkg::OP_UPSERT, 32'hDEAD_0002, 32'h2, 4'd0);   // full, absent
        drive_request(okvt_pkg::OP_UPSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 4'd0);
        drive_request(okvt_pkg::OP_INSERT, 32'h0, 32'h5555_5555, 4'd0);   // present
        drive_request(okvt_pkg::OP_READ_AT, 32'h0, 32'h0, 4'd15);
        drive_request(okvt_pkg::OP_ERASE, 32'h103, 32'h0, 4'd0);          // middle
        drive_request(okvt_pkg::OP_READ_AT, 32'h0, 32'h0, 4'd15);         // now out of range
        drive_request(okvt_pkg::OP_UPDATE, 32'h0, 32'h5555_5555, 4'd0);
        drive_request(okvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
        drive_request(OP_RSVD_6, 32'hCAFE_F00D, 32'hFFFF_FFFF, 4'd15);
        drive_request(OP_RSVD_7, 32'h8000_0001, 32'h1234_5678, 4'd7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            logic [okvt_pkg::TUSER_W-1:0] op;
            quiet = (n >= 300 && n < 550);
            if (n == 700) hold_request = 1'b1;
            op = pick_op(((n / 150) % 2) == 0);
            k  = pick_key();
            if (sb.count > 0 && $urandom_range(99) < 70) begin
                p = okvt_pkg::POS_W'($urandom_range(sb.count - 1));
            end else begin
                p = okvt_pkg::POS_W'($urandom_range(15));
            end
            drive_request(op, k, $urandom, p);
        end
        quiet = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ordered_key_value_table: match");
        end else begin
            $display("ordered_key_value_table: mismatch");
        end
        $finish;
    end

endmodule
